@@ rtl/alc_pkg.sv @@
// Shared types, constants and helpers of the AT response line classifier.
`timescale 1ns / 1ps

package alc_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int PREFIX_BYTES_DEF = 8;

  localparam int PFX_W     = 64;
  localparam int PFX_IDX_W = 4;
  localparam int CNT_W     = 7;
  localparam int CLS_W     = 3;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX     = 7'd127;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic {
    CMD_RX   = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_e;

  typedef enum logic {
    NL_CRLF = 1'b0,
    NL_LF   = 1'b1
  } nl_mode_e;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE   = 3'd0,
    CLS_INIT   = 3'd1,
    CLS_OK     = 3'd2,
    CLS_ERROR  = 3'd3,
    CLS_CUSTOM = 3'd4,
    CLS_OTHER  = 3'd5
  } line_class_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NEWLINE_MODE  = 3'd0,
    REG_OK_PREFIX     = 3'd1,
    REG_ERROR_PREFIX  = 3'd2,
    REG_CUSTOM_PREFIX = 3'd3,
    REG_INIT_PREFIX   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_EMPTY,
    ST_MATCH,
    ST_CMP,
    ST_SRD,
    ST_SCHK
  } ctrl_state_e;

  typedef struct packed {
    nl_mode_e         newline_mode;
    logic [PFX_W-1:0] pfx_ok;
    logic [PFX_W-1:0] pfx_err;
    logic [PFX_W-1:0] pfx_cus;
    logic [PFX_W-1:0] pfx_init;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 7'd1;
  endfunction

endpackage

@@ rtl/at_response_line_classifier_unit.sv @@
// Top level of the AT response line classifier: config registers and wiring.
//
// Input stream: tuser is the command (0 receive rx_byte in tdata, 1 take
// the oldest line). A receive word frames the byte into lines (CR LF or LF
// mode) and stores data and a zero terminator in the line ring, storing or
// dropping (ring full) zero to two bytes per word. A take word classifies
// the oldest line against the init (once armed), ok, error and custom
// prefixes, comparing each prefix byte with a byte read from the ring, then
// streams the line, reading up to and including its terminator (at most
// 64 characters), one output word per character, lagging one character,
// tlast on the final word. The compare unit and the ring read port are
// shared by all of this; the input is not ready until the take finishes.
// Output stream: tuser carries line_class and char_valid, tdata line_char and
// lines_pending. A one-word output register holds each result; a stalled
// receiver stalls the sequencer and nothing is lost.
// Config channel: cfg_index_i selects the register; writes must be issued
// only while the block is idle (not enforced by it); writing the init
// prefix arms the init match. Reset clears registers, pointers and counters.
`timescale 1ns / 1ps

module at_response_line_classifier_unit #(
  parameter int BUFFER_DEPTH = alc_pkg::BUFFER_DEPTH_DEF,
  parameter int PREFIX_BYTES = alc_pkg::PREFIX_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // rx_byte
  input  logic                          s_axis_tuser,  // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // line_char, lines_pending, pad
  output logic [3:0]                    m_axis_tuser,  // line_class, char_valid
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [alc_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [alc_pkg::PFX_W-1:0]     cfg_data_i
);

  import alc_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  cfg_t          cfg_q;
  logic          cfg_wr;
  logic          init_arm;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign init_arm    = cfg_wr && (cfg_reg_e'(cfg_index_i) == REG_INIT_PREFIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_NEWLINE_MODE:  cfg_q.newline_mode <= nl_mode_e'(cfg_data_i[0]);
        REG_OK_PREFIX:     cfg_q.pfx_ok       <= cfg_data_i;
        REG_ERROR_PREFIX:  cfg_q.pfx_err      <= cfg_data_i;
        REG_CUSTOM_PREFIX: cfg_q.pfx_cus      <= cfg_data_i;
        REG_INIT_PREFIX:   cfg_q.pfx_init     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  alc_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PREFIX_BYTES (PREFIX_BYTES),
    .AW           (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .init_arm_i    (init_arm),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data)
  );

  alc_ring_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

@@ rtl/alc_ring_mem.sv @@
// Line ring store: one write port, one registered read port.
`timescale 1ns / 1ps

module alc_ring_mem #(
  parameter int DEPTH = alc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/alc_ctrl.sv @@
// Sequencer: line framing, prefix compare, line streaming and output register.
`timescale 1ns / 1ps

module alc_ctrl #(
  parameter int BUFFER_DEPTH = alc_pkg::BUFFER_DEPTH_DEF,
  parameter int PREFIX_BYTES = alc_pkg::PREFIX_BYTES_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alc_pkg::cfg_t cfg_i,
  input  logic          init_arm_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // rx_byte
  input  logic          s_axis_tuser,   // command
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata,   // line_char, lines_pending, pad
  output logic [3:0]    m_axis_tuser,   // line_class, char_valid
  output logic          m_axis_tlast,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i
);

  import alc_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW-1:0]        LAST_SLOT = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0]        FULL_CNT  = CW'(BUFFER_DEPTH);
  localparam logic [PFX_IDX_W-1:0] PB_END    = PFX_IDX_W'(PREFIX_BYTES);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  ctrl_state_e          state_q, state_d;
  logic [AW-1:0]        wp_q, wp_d, rp_q, rp_d, pos_q, pos_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CNT_W-1:0]     len_q, len_d, lines_q, lines_d, n_q, n_d;
  logic [7:0]           prev_q, prev_d;
  logic                 init_wait_q, init_wait_d;
  logic [1:0]           pend_cnt_q, pend_cnt_d;
  logic [7:0]           pend0_q, pend0_d, pend1_q, pend1_d;
  line_class_e          sel_q, sel_d, cls_q, cls_d;
  logic [PFX_IDX_W-1:0] idx_q, idx_d;
  logic                 have_q, have_d;
  logic [7:0]           held_q, held_d;

  logic                 ov_q, ov_d;
  line_class_e          o_cls_q, o_cls_d;
  logic [7:0]           o_char_q, o_char_d;
  logic                 o_cv_q, o_cv_d, o_last_q, o_last_d;
  logic [CNT_W-1:0]     o_pend_q, o_pend_d;

  logic                 out_ready;
  logic [PFX_W-1:0]     cur_pfx;
  logic [7:0]           pbyte;
  logic [7:0]           rx_b;
  logic                 do_match, do_fail, finish;

  assign rx_b      = s_axis_tdata;
  assign out_ready = !ov_q || m_axis_tready;

  always_comb begin
    case (sel_q)
      CLS_INIT:  cur_pfx = cfg_i.pfx_init;
      CLS_OK:    cur_pfx = cfg_i.pfx_ok;
      CLS_ERROR: cur_pfx = cfg_i.pfx_err;
      default:   cur_pfx = cfg_i.pfx_cus;
    endcase
  end

  assign pbyte = cur_pfx[{idx_q[2:0], 3'b000} +: 8];

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    len_d       = len_q;
    lines_d     = lines_q;
    n_d         = n_q;
    prev_d      = prev_q;
    init_wait_d = init_wait_q;
    pend_cnt_d  = pend_cnt_q;
    pend0_d     = pend0_q;
    pend1_d     = pend1_q;
    sel_d       = sel_q;
    cls_d       = cls_q;
    idx_d       = idx_q;
    have_d      = have_q;
    held_d      = held_q;
    ov_d        = ov_q && !m_axis_tready;
    o_cls_d     = o_cls_q;
    o_char_d    = o_char_q;
    o_cv_d      = o_cv_q;
    o_last_d    = o_last_q;
    o_pend_d    = o_pend_q;
    wr_en_o     = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = rp_q;
    do_match    = 1'b0;
    do_fail     = 1'b0;
    finish      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (cmd_e'(s_axis_tuser) == CMD_RX) begin
            if (cfg_i.newline_mode == NL_CRLF) begin
              prev_d = rx_b;
              if (rx_b == CH_CR) begin
                if (prev_q == CH_CR) begin
                  pend0_d    = CH_CR;
                  pend_cnt_d = 2'd1;
                  len_d      = sat_inc(len_q);
                end
              end else if (rx_b == CH_LF && prev_q == CH_CR) begin
                if (len_q != '0) begin
                  pend0_d    = 8'h00;
                  pend_cnt_d = 2'd1;
                  lines_d    = sat_inc(lines_q);
                  len_d      = '0;
                end
              end else if (prev_q == CH_CR) begin
                pend0_d    = CH_CR;
                pend1_d    = rx_b;
                pend_cnt_d = 2'd2;
                len_d      = sat_inc(sat_inc(len_q));
              end else begin
                pend0_d    = rx_b;
                pend_cnt_d = 2'd1;
                len_d      = sat_inc(len_q);
              end
            end else if (rx_b == CH_LF) begin
              if (len_q != '0) begin
                pend0_d    = 8'h00;
                pend_cnt_d = 2'd1;
                lines_d    = sat_inc(lines_q);
                len_d      = '0;
              end
            end else begin
              pend0_d    = rx_b;
              pend_cnt_d = 2'd1;
              len_d      = sat_inc(len_q);
            end
            if (pend_cnt_d != 2'd0) begin
              state_d = ST_STORE;
            end
          end else if (lines_q == '0) begin
            state_d = ST_EMPTY;
          end else begin
            lines_d = lines_q - 7'd1;
            sel_d   = init_wait_q ? CLS_INIT : CLS_OK;
            idx_d   = '0;
            pos_d   = rp_q;
            n_d     = '0;
            have_d  = 1'b0;
            state_d = ST_MATCH;
          end
        end
      end

      ST_STORE: begin
        if (fill_q < FULL_CNT) begin
          wr_en_o = 1'b1;
          wp_d    = nxt(wp_q);
          fill_d  = fill_q + 1'b1;
        end
        pend0_d    = pend1_q;
        pend_cnt_d = pend_cnt_q - 2'd1;
        if (pend_cnt_q == 2'd1) begin
          state_d = ST_IDLE;
        end
      end

      ST_EMPTY: begin
        if (out_ready) begin
          ov_d     = 1'b1;
          o_cls_d  = CLS_NONE;
          o_char_d = 8'h00;
          o_cv_d   = 1'b0;
          o_last_d = 1'b1;
          o_pend_d = '0;
          state_d  = ST_IDLE;
        end
      end

      ST_MATCH: begin
        if (idx_q == PB_END || pbyte == 8'h00) begin
          if (idx_q == '0) begin
            do_fail = 1'b1;
          end else begin
            do_match = 1'b1;
          end
        end else if (CNT_W'(idx_q) >= CNT_W'(fill_q)) begin
          do_fail = 1'b1;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = pos_q;
          state_d   = ST_CMP;
        end
      end

      ST_CMP: begin
        if (rd_data_i == pbyte) begin
          idx_d   = idx_q + 1'b1;
          pos_d   = nxt(pos_q);
          state_d = ST_MATCH;
        end else begin
          do_fail = 1'b1;
        end
      end

      ST_SRD: begin
        if (fill_q == '0 || n_q == MAX_RESULTS) begin
          finish = 1'b1;
        end else begin
          rd_en_o = 1'b1;
          rp_d    = nxt(rp_q);
          fill_d  = fill_q - 1'b1;
          state_d = ST_SCHK;
        end
      end

      ST_SCHK: begin
        if (rd_data_i == 8'h00) begin
          finish = 1'b1;
        end else if (!have_q) begin
          held_d  = rd_data_i;
          have_d  = 1'b1;
          n_d     = n_q + 7'd1;
          state_d = ST_SRD;
        end else if (out_ready) begin
          ov_d     = 1'b1;
          o_cls_d  = cls_q;
          o_char_d = held_q;
          o_cv_d   = 1'b1;
          o_last_d = 1'b0;
          o_pend_d = lines_q;
          held_d   = rd_data_i;
          n_d      = n_q + 7'd1;
          state_d  = ST_SRD;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (do_match) begin
      cls_d   = sel_q;
      state_d = ST_SRD;
      if (sel_q == CLS_INIT) begin
        init_wait_d = 1'b0;
      end
    end else if (do_fail) begin
      idx_d   = '0;
      pos_d   = rp_q;
      state_d = ST_MATCH;
      case (sel_q)
        CLS_INIT:  sel_d = CLS_OK;
        CLS_OK:    sel_d = CLS_ERROR;
        CLS_ERROR: sel_d = CLS_CUSTOM;
        default: begin
          cls_d   = CLS_OTHER;
          state_d = ST_SRD;
        end
      endcase
    end

    if (finish && out_ready) begin
      ov_d     = 1'b1;
      o_cls_d  = cls_q;
      o_char_d = have_q ? held_q : 8'h00;
      o_cv_d   = have_q;
      o_last_d = 1'b1;
      o_pend_d = lines_q;
      state_d  = ST_IDLE;
    end

    if (init_arm_i) begin
      init_wait_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      lines_q     <= '0;
      prev_q      <= 8'h00;
      init_wait_q <= 1'b0;
      pend_cnt_q  <= 2'd0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      lines_q     <= lines_d;
      prev_q      <= prev_d;
      init_wait_q <= init_wait_d;
      pend_cnt_q  <= pend_cnt_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    n_q      <= n_d;
    pend0_q  <= pend0_d;
    pend1_q  <= pend1_d;
    sel_q    <= sel_d;
    cls_q    <= cls_d;
    idx_q    <= idx_d;
    have_q   <= have_d;
    held_q   <= held_d;
    o_cls_q  <= o_cls_d;
    o_char_q <= o_char_d;
    o_cv_q   <= o_cv_d;
    o_last_q <= o_last_d;
    o_pend_q <= o_pend_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign wr_addr_o     = wp_q;
  assign wr_data_o     = pend0_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, o_pend_q, o_char_q};
  assign m_axis_tuser  = {o_cv_q, o_cls_q};
  assign m_axis_tlast  = o_last_q;

endmodule

@@ verif/tb_at_response_line_classifier_unit.sv @@
// Self-checking testbench of the AT response line classifier unit.
`timescale 1ns / 1ps

module tb_at_response_line_classifier_unit;
  import alc_pkg::*;

  localparam int RING_DEPTH    = BUFFER_DEPTH_DEF;
  localparam int PFX_LEN       = PREFIX_BYTES_DEF;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_WORDS   = 26;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    line_class_e cls;
    logic [7:0]  ch;
    logic        valid;
    logic        last;
    logic [6:0]  pending;
  } line_word_t;

  class line_classifier_model;
    nl_mode_e    mode      = NL_CRLF;
    logic [63:0] ok_pfx    = '0;
    logic [63:0] err_pfx   = '0;
    logic [63:0] cus_pfx   = '0;
    logic [63:0] init_pfx  = '0;
    logic [7:0]  ring [RING_DEPTH];
    int unsigned wr_ptr    = 0;
    int unsigned rd_ptr    = 0;
    int unsigned fill      = 0;
    int unsigned cur_len   = 0;
    int unsigned lines     = 0;
    logic [7:0]  prev_byte = 8'h00;
    bit          init_armed = 1'b0;
    line_word_t  expected_words [$];
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;

    function void push_byte(logic [7:0] b);
      if (fill < RING_DEPTH) begin
        ring[wr_ptr] = b;
        fill++;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      end
    endfunction

    function logic [7:0] pop_byte();
      logic [7:0] b;
      if (fill == 0) return 8'h00;
      b = ring[rd_ptr];
      fill--;
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      return b;
    endfunction

    function void add_char(logic [7:0] b);
      push_byte(b);
      if (cur_len < 127) cur_len++;
    endfunction

    function void close_line();
      if (cur_len != 0) begin
        push_byte(8'h00);
        if (lines < 127) lines++;
        cur_len = 0;
      end
    endfunction

    function bit prefix_hit(logic [63:0] p);
      int unsigned pos;
      logic [7:0]  c;
      pos = rd_ptr;
      if (p[7:0] == 8'h00) return 1'b0;
      for (int i = 0; i < PFX_LEN; i++) begin
        c = p[8*i +: 8];
        if (c == 8'h00) break;
        if (i >= fill) return 1'b0;
        if (ring[pos] != c) return 1'b0;
        pos = (pos + 1) % RING_DEPTH;
      end
      return 1'b1;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] v);
      case (idx)
        REG_NEWLINE_MODE:  mode = nl_mode_e'(v[0]);
        REG_OK_PREFIX:     ok_pfx = v;
        REG_ERROR_PREFIX:  err_pfx = v;
        REG_CUSTOM_PREFIX: cus_pfx = v;
        REG_INIT_PREFIX: begin
          init_pfx = v;
          init_armed = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void note_word(cmd_e cmd, logic [7:0] b);
      line_class_e cls;
      logic [7:0]  c;
      int          n;
      line_word_t  w;
      if (cmd == CMD_RX) begin
        if (mode == NL_CRLF) begin
          if (b == CH_CR) begin
            if (prev_byte == CH_CR) add_char(CH_CR);
          end else if (b == CH_LF && prev_byte == CH_CR) begin
            close_line();
          end else begin
            // a held CR followed by other data is kept as data
            if (prev_byte == CH_CR) add_char(CH_CR);
            add_char(b);
          end
          prev_byte = b;
        end else begin
          if (b == CH_LF) close_line();
          else add_char(b);
        end
        return;
      end
      if (lines == 0) begin
        w = '{CLS_NONE, 8'h00, 1'b0, 1'b1, 7'd0};
        expected_words.push_back(w);
        return;
      end
      lines--;
      if (init_armed && prefix_hit(init_pfx)) begin
        cls = CLS_INIT;
        init_armed = 1'b0;
      end else if (prefix_hit(ok_pfx)) begin
        cls = CLS_OK;
      end else if (prefix_hit(err_pfx)) begin
        cls = CLS_ERROR;
      end else if (prefix_hit(cus_pfx)) begin
        cls = CLS_CUSTOM;
      end else begin
        cls = CLS_OTHER;
      end
      n = 0;
      while (fill != 0 && n < int'(MAX_RESULTS)) begin
        c = pop_byte();
        if (c == 8'h00) break;
        w = '{cls, c, 1'b1, 1'b0, 7'(lines)};
        expected_words.push_back(w);
        n++;
      end
      if (n == 0) begin
        w = '{cls, 8'h00, 1'b0, 1'b1, 7'(lines)};
        expected_words.push_back(w);
      end else begin
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
      end
    endfunction

    task log_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch at word %0d: %s got %0h want %0h", words_checked, what, got, want);
    endtask

    task check_word(logic [15:0] data, logic [3:0] user, logic last_bit);
      line_word_t w;
      words_checked++;
      if (expected_words.size() == 0) begin
        log_mismatch("unexpected word", int'(data), 0);
        return;
      end
      w = expected_words.pop_front();
      if (user[2:0] !== w.cls) log_mismatch("line_class", int'(user[2:0]), int'(w.cls));
      if (user[3] !== w.valid) log_mismatch("char_valid", int'(user[3]), int'(w.valid));
      if (data[7:0] !== w.ch) log_mismatch("line_char", int'(data[7:0]), int'(w.ch));
      if (data[14:8] !== w.pending)
        log_mismatch("lines_pending", int'(data[14:8]), int'(w.pending));
      if (last_bit !== w.last) log_mismatch("last", int'(last_bit), int'(w.last));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [PFX_W-1:0]     cfg_data_i  = '0;

  line_classifier_model model = new();

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_left     = 0;
  int sent_items    = 0;

  at_response_line_classifier_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: check each accepted word, then choose tready for the next edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        model.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  function automatic logic [63:0] pack_prefix(string s);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < s.len() && i < PFX_LEN; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  function automatic logic [63:0] rand_prefix();
    logic [63:0] p;
    int          len;
    int          r;
    p = '0;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return {$urandom, $urandom};
    len = $urandom_range(PFX_LEN, 1);
    for (int i = 0; i < len; i++) p[8*i +: 8] = 8'($urandom_range(126, 33));
    if (r == 2) p[7:0] = 8'h00;
    return p;
  endfunction

  function automatic logic [7:0] rand_char(bit raw_ok);
    if (raw_ok && $urandom_range(15) == 0) return 8'($urandom);
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic send_word(cmd_e cmd, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    model.note_word(cmd, b);
    sent_items++;
  endtask

  task automatic take_line();
    send_word(CMD_TAKE, 8'($urandom));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_RX, s[i]);
  endtask

  // line that often opens with part or all of a programmed prefix
  task automatic send_line(int tail_len, bit clean_end);
    logic [63:0] p;
    int          plen;
    case ($urandom_range(4))
      0:       p = model.ok_pfx;
      1:       p = model.err_pfx;
      2:       p = model.cus_pfx;
      3:       p = model.init_pfx;
      default: p = '0;
    endcase
    plen = $urandom_range(PFX_LEN);
    for (int i = 0; i < plen; i++) begin
      if (p[8*i +: 8] == 8'h00) break;
      send_word(CMD_RX, p[8*i +: 8]);
    end
    repeat (tail_len) send_word(CMD_RX, rand_char(1'b1));
    if (clean_end) begin
      if (model.mode == NL_CRLF) send_word(CMD_RX, CH_CR);
      send_word(CMD_RX, CH_LF);
    end else if ($urandom_range(1) == 0) begin
      send_word(CMD_RX, CH_CR);
      send_word(CMD_RX, rand_char(1'b0));
    end else begin
      send_word(CMD_RX, CH_LF);
    end
  endtask

  task automatic do_sequence();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: send_line($urandom_range(8), 1'b1);
      5:             send_line($urandom_range(8), 1'b0);
      6, 7:          repeat ($urandom_range(2, 1)) take_line();
      8:             send_word(CMD_RX, 8'($urandom));
      default:       send_line($urandom_range(70, 16), 1'b1);
    endcase
    if (model.lines > 4) take_line();
  endtask

  // wait for the last expected word, then let a receive in flight finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (model.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_reg(idx, v);
  endtask

  task automatic write_config(nl_mode_e m, logic [63:0] ok_p, logic [63:0] err_p,
                              logic [63:0] cus_p, logic [63:0] init_p);
    write_reg(REG_NEWLINE_MODE, 64'(m));
    write_reg(REG_OK_PREFIX, ok_p);
    write_reg(REG_ERROR_PREFIX, err_p);
    write_reg(REG_CUSTOM_PREFIX, cus_p);
    write_reg(REG_INIT_PREFIX, init_p);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int src_tab [4];
    int snk_tab [4];
    int phase_start;
    src_tab = '{0, 49, 0, 8};
    snk_tab = '{0, 0, 49, 8};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty take with reset config
    take_line();
    settle();
    write_config(NL_CRLF, pack_prefix("OK"), pack_prefix("ERROR"), pack_prefix("+C"),
                 pack_prefix("RDY"));
    send_text("RDY\r\n");
    // lone CR before other data, top byte value
    send_word(CMD_RX, CH_CR);
    send_word(CMD_RX, 8'hFF);
    send_text("\r\n");
    // line shorter than the error prefix
    send_text("ER\r\n");
    repeat (3) take_line();
    settle();
    write_config(NL_LF, pack_prefix("OK"), pack_prefix("ERROR"), pack_prefix("+C"),
                 pack_prefix("RDY"));
    // zero data byte cuts the streamed line short
    send_text("OK");
    send_word(CMD_RX, 8'h00);
    send_text("+\n");
    repeat (2) take_line();

    for (int ph = 0; ph < 8; ph++) begin
      nl_mode_e    m;
      logic [63:0] p_ok;
      logic [63:0] p_err;
      logic [63:0] p_cus;
      logic [63:0] p_init;
      settle();
      src_idle_pct  = src_tab[ph % 4];
      snk_stall_pct = snk_tab[ph % 4];
      if (ph == 0) begin
        m = NL_LF;
        p_ok = '1; p_err = '1; p_cus = '1; p_init = '1;
      end else if (ph == 1) begin
        m = NL_CRLF;
        p_ok = '0; p_err = '0; p_cus = '0; p_init = '0;
      end else begin
        m = nl_mode_e'($urandom_range(1));
        p_ok = rand_prefix(); p_err = rand_prefix();
        p_cus = rand_prefix(); p_init = rand_prefix();
      end
      if (ph == 6) m = NL_LF;
      write_config(m, p_ok, p_err, p_cus, p_init);

      if (ph == 4) hold_left = HOLD_CYCLES;
      if (ph == 6) begin
        // overlong line saturates the length counter and overflows the ring
        repeat (130) send_word(CMD_RX, rand_char(1'b0));
        send_word(CMD_RX, CH_LF);
        while (model.lines != 0) take_line();
      end

      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_WORDS) do_sequence();
    end

    settle();
    if (model.mismatches == 0 && model.expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ at_response_line_classifier_unit.f @@
rtl/alc_pkg.sv
rtl/alc_ring_mem.sv
rtl/alc_ctrl.sv
rtl/at_response_line_classifier_unit.sv
verif/tb_at_response_line_classifier_unit.sv
